// ----- rtl/core/lab_pkg.sv -----
// Shared types and constants of the look-at basis block.
`default_nettype none
package lab_pkg;
	localparam int IN_W = 32;
	localparam int OUT_W = 16;
	localparam int VEC_W = 31;
	localparam int OUT_FRAC_DEF = 14;

	typedef struct packed {
		logic signed [IN_W-1:0] eye_x;
		logic signed [IN_W-1:0] eye_y;
		logic signed [IN_W-1:0] eye_z;
		logic signed [IN_W-1:0] up_x;
		logic signed [IN_W-1:0] up_y;
		logic signed [IN_W-1:0] up_z;
		logic signed [IN_W-1:0] target_x;
		logic signed [IN_W-1:0] target_y;
		logic signed [IN_W-1:0] target_z;
	} in_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] right_x;
		logic signed [OUT_W-1:0] right_y;
		logic signed [OUT_W-1:0] right_z;
		logic signed [OUT_W-1:0] upward_x;
		logic signed [OUT_W-1:0] upward_y;
		logic signed [OUT_W-1:0] upward_z;
		logic signed [OUT_W-1:0] back_x;
		logic signed [OUT_W-1:0] back_y;
		logic signed [OUT_W-1:0] back_z;
		logic                    degenerate;
	} out_t;

	typedef struct packed {
		logic valid;
		logic degenerate;
	} tag_t;
endpackage
`default_nettype wire

// ----- rtl/core/lab_in_if.sv -----
// Request channel carrying eye, up and target vectors.
`default_nettype none
interface lab_in_if;
	logic         valid;
	logic         ready;
	lab_pkg::in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/lab_out_if.sv -----
// Result channel carrying the unit camera basis.
`default_nettype none
interface lab_out_if;
	logic          valid;
	logic          ready;
	lab_pkg::out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/lab_nrm.sv -----
// Pipelined normalizer: square sum, bit-pair square root, restoring divide.
`default_nettype none
module lab_nrm #(
	parameter int OUT_FRAC_BITS = lab_pkg::OUT_FRAC_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic [8:0][lab_pkg::VEC_W-1:0]      vec,
	input  lab_pkg::tag_t                       tag,
	output logic [8:0][lab_pkg::OUT_W-1:0]      res,
	output lab_pkg::tag_t                       res_tag
);
	localparam int VW = lab_pkg::VEC_W;
	localparam int OW = lab_pkg::OUT_W;
	localparam int SQ_W = 2 * VW;
	localparam int RS = VW;
	localparam int DS = OUT_FRAC_BITS + 1;
	localparam int N_W = VW + OUT_FRAC_BITS + 1;
	localparam int Q_W = OUT_FRAC_BITS + 1;
	localparam int CW = (Q_W > 17) ? Q_W : 17;
	localparam logic [CW-1:0] Q_MAX = CW'(32768);

	logic [8:0][VW-1:0]            mag;
	logic [8:0]                    neg;
	logic [RS-1:0][2:0][SQ_W-1:0]  trial;
	logic [RS-1:0][2:0]            fits;
	logic [DS-1:0][8:0][N_W-1:0]   dsor;
	logic [DS-1:0][8:0]            ge;
	logic [8:0][CW-1:0]            qc;
	logic [8:0][CW-1:0]            fin;

	logic [8:0][SQ_W-1:0]          sq_s1;
	logic [8:0][VW-1:0]            mag_s1;
	logic [8:0]                    neg_s1;
	lab_pkg::tag_t                 tag_s1;

	logic [2:0][SQ_W-1:0]          rem_r  [RS];
	logic [2:0][SQ_W-1:0]          root_r [RS+1];
	logic [8:0][VW-1:0]            mag_r  [RS+1];
	logic [8:0]                    neg_r  [RS+1];
	lab_pkg::tag_t                 tag_r  [RS+1];

	logic [8:0][N_W-1:0]           rem_d  [DS];
	logic [8:0][Q_W-1:0]           quo_d  [DS+1];
	logic [2:0][VW-1:0]            len_d  [DS];
	logic [8:0]                    neg_d  [DS+1];
	lab_pkg::tag_t                 tag_d  [DS+1];

	logic [8:0][OW-1:0]            res_q;
	lab_pkg::tag_t                 tag_q;

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			neg[k] = vec[k][VW-1];
			mag[k] = neg[k] ? VW'(~vec[k] + 1'b1) : vec[k];
		end
		for (int j = 0; j < RS; j++) begin
			for (int g = 0; g < 3; g++) begin
				trial[j][g] = root_r[j][g] + (SQ_W'(1) << (2 * (RS - 1 - j)));
				if (j < RS - 1) begin
					fits[j][g] = rem_r[j][g] >= trial[j][g];
				end else begin
					fits[j][g] = rem_r[j][g] >= trial[j][g];
				end
			end
		end
		for (int t = 0; t < DS; t++) begin
			for (int g = 0; g < 3; g++) begin
				for (int c = 0; c < 3; c++) begin
					dsor[t][3*g+c] = N_W'(len_d[t][g]) << (OUT_FRAC_BITS - t);
					ge[t][3*g+c] = rem_d[t][3*g+c] >= dsor[t][3*g+c];
				end
			end
		end
		for (int k = 0; k < 9; k++) begin
			qc[k] = (CW'(quo_d[DS][k]) > Q_MAX) ? Q_MAX : CW'(quo_d[DS][k]);
			if (neg_d[DS][k]) begin
				fin[k] = ~qc[k] + 1'b1;
			end else if (qc[k] == Q_MAX) begin
				fin[k] = Q_MAX - 1'b1;
			end else begin
				fin[k] = qc[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				sq_s1[k] <= SQ_W'(mag[k]) * SQ_W'(mag[k]);
			end
			mag_s1 <= mag;
			neg_s1 <= neg;

			for (int g = 0; g < 3; g++) begin
				rem_r[0][g] <= sq_s1[3*g] + sq_s1[3*g+1] + sq_s1[3*g+2];
				root_r[0][g] <= '0;
			end
			mag_r[0] <= mag_s1;
			neg_r[0] <= neg_s1;

			// one result bit per stage
			for (int j = 0; j < RS; j++) begin
				for (int g = 0; g < 3; g++) begin
					if (fits[j][g]) begin
						if (j < RS - 1) begin
							rem_r[j+1][g] <= rem_r[j][g] - trial[j][g];
						end
						root_r[j+1][g] <= (root_r[j][g] >> 1)
							+ (SQ_W'(1) << (2 * (RS - 1 - j)));
					end else begin
						if (j < RS - 1) begin
							rem_r[j+1][g] <= rem_r[j][g];
						end
						root_r[j+1][g] <= root_r[j][g] >> 1;
					end
				end
				mag_r[j+1] <= mag_r[j];
				neg_r[j+1] <= neg_r[j];
			end

			// rounded dividend: |c| scaled up plus half the length
			for (int g = 0; g < 3; g++) begin
				len_d[0][g] <= root_r[RS][g][VW-1:0];
				for (int c = 0; c < 3; c++) begin
					rem_d[0][3*g+c] <= (N_W'(mag_r[RS][3*g+c]) << OUT_FRAC_BITS)
						+ N_W'(root_r[RS][g][VW-1:1]);
				end
			end
			quo_d[0] <= '0;
			neg_d[0] <= neg_r[RS];

			for (int t = 0; t < DS; t++) begin
				for (int k = 0; k < 9; k++) begin
					if (t < DS - 1) begin
						rem_d[t+1][k] <= ge[t][k] ? rem_d[t][k] - dsor[t][k] : rem_d[t][k];
					end
					quo_d[t+1][k] <= quo_d[t][k]
						| (Q_W'(ge[t][k]) << (OUT_FRAC_BITS - t));
				end
				if (t < DS - 1) begin
					len_d[t+1] <= len_d[t];
				end
				neg_d[t+1] <= neg_d[t];
			end

			for (int k = 0; k < 9; k++) begin
				res_q[k] <= tag_d[DS].degenerate ? '0 : fin[k][OW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			for (int j = 0; j <= RS; j++) begin
				tag_r[j] <= '0;
			end
			for (int t = 0; t <= DS; t++) begin
				tag_d[t] <= '0;
			end
			tag_q <= '0;
		end else if (en) begin
			tag_s1 <= tag;
			tag_r[0] <= tag_s1;
			for (int j = 0; j < RS; j++) begin
				tag_r[j+1] <= tag_r[j];
			end
			tag_d[0] <= tag_r[RS];
			for (int t = 0; t < DS; t++) begin
				tag_d[t+1] <= tag_d[t];
			end
			tag_q <= tag_d[DS];
		end
	end

	assign res = res_q;
	assign res_tag = tag_q;
endmodule
`default_nettype wire

// ----- rtl/core/look_at_basis.sv -----
// Look-at camera basis: back = eye - target, right = up x back, upward = back x right,
// each scaled to a unit vector in signed fixed point with OUT_FRAC_BITS fraction bits.
// The block is a single stall-as-a-whole pipeline: it takes one request per clock
// while the output is not held and returns one result per request, in order. It is
// built of eleven stages of block scaling and cross products, a square stage, a sum
// stage, a 31-stage square root, a dividend stage, a divider of OUT_FRAC_BITS + 1
// stages and the output register. When the output is held, every stage holds and no
// request is taken. A zero-length vector anywhere in the chain gives all-zero outputs
// with degenerate set.
`default_nettype none
module look_at_basis #(
	parameter int OUT_FRAC_BITS = lab_pkg::OUT_FRAC_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lab_in_if.sink     item,
	lab_out_if.source  result
);
	localparam int VW = lab_pkg::VEC_W;
	localparam int NORM_TOP = 30;

	function automatic logic [6:0] bit_len(input logic [63:0] v);
		logic [6:0] n;
		n = '0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) begin
				n = 7'(i + 1);
			end
		end
		return n;
	endfunction

	// OR of magnitudes has the same bit length as the largest magnitude
	function automatic logic [63:0] mag_or(input logic [2:0][63:0] v);
		logic [63:0] acc;
		acc = '0;
		for (int i = 0; i < 3; i++) begin
			acc = acc | (v[i][63] ? (~v[i] + 64'd1) : v[i]);
		end
		return acc;
	endfunction

	function automatic logic [VW-1:0] scale(input logic [63:0] v, input logic [6:0] n);
		logic [63:0] r;
		if (n < 7'(NORM_TOP)) begin
			r = v << (7'(NORM_TOP) - n);
		end else begin
			r = $unsigned($signed(v) >>> (n - 7'(NORM_TOP)));
		end
		return r[VW-1:0];
	endfunction

	logic en;
	logic [2:0][31:0] eye, upv, tgt;

	logic [2:0][63:0]   bk_s1, bk_s2;
	logic [2:0][31:0]   up_s1, up_s2, up_s3;
	logic [6:0]         bkn_s2, rtn_s6, uwn_s10;
	logic [2:0][VW-1:0] bks_s3, bks_s4, bks_s5, bks_s6, bks_s7, bks_s8, bks_s9;
	logic [2:0][VW-1:0] bks_s10, bks_s11;
	logic signed [63:0] prd_s4 [6];
	logic signed [63:0] prd_s8 [6];
	logic [2:0][63:0]   rt_s5, rt_s6, uw_s9, uw_s10;
	logic [2:0][VW-1:0] rts_s7, rts_s8, rts_s9, rts_s10, rts_s11, uws_s11;
	logic dg_s3, dg_s4, dg_s5, dg_s6, dg_s7, dg_s8, dg_s9, dg_s10, dg_s11;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic vld_s10, vld_s11;

	logic [8:0][VW-1:0]             nrm_vec;
	lab_pkg::tag_t                  nrm_tag;
	logic [8:0][lab_pkg::OUT_W-1:0] res;
	lab_pkg::tag_t                  res_tag;

	assign en = !result.valid || result.ready;
	assign item.ready = en;

	assign eye = {item.data.eye_z, item.data.eye_y, item.data.eye_x};
	assign upv = {item.data.up_z, item.data.up_y, item.data.up_x};
	assign tgt = {item.data.target_z, item.data.target_y, item.data.target_x};

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				bk_s1[i] <= 64'($signed(eye[i])) - 64'($signed(tgt[i]));
			end
			up_s1 <= upv;

			bkn_s2 <= bit_len(mag_or(bk_s1));
			bk_s2 <= bk_s1;
			up_s2 <= up_s1;

			for (int i = 0; i < 3; i++) begin
				bks_s3[i] <= scale(bk_s2[i], bkn_s2);
			end
			dg_s3 <= bkn_s2 == '0;
			up_s3 <= up_s2;

			// right = up x back
			prd_s4[0] <= $signed(up_s3[1]) * $signed(bks_s3[2]);
			prd_s4[1] <= $signed(up_s3[2]) * $signed(bks_s3[1]);
			prd_s4[2] <= $signed(up_s3[2]) * $signed(bks_s3[0]);
			prd_s4[3] <= $signed(up_s3[0]) * $signed(bks_s3[2]);
			prd_s4[4] <= $signed(up_s3[0]) * $signed(bks_s3[1]);
			prd_s4[5] <= $signed(up_s3[1]) * $signed(bks_s3[0]);
			bks_s4 <= bks_s3;
			dg_s4 <= dg_s3;

			rt_s5[0] <= prd_s4[0] - prd_s4[1];
			rt_s5[1] <= prd_s4[2] - prd_s4[3];
			rt_s5[2] <= prd_s4[4] - prd_s4[5];
			bks_s5 <= bks_s4;
			dg_s5 <= dg_s4;

			rtn_s6 <= bit_len(mag_or(rt_s5));
			rt_s6 <= rt_s5;
			bks_s6 <= bks_s5;
			dg_s6 <= dg_s5;

			for (int i = 0; i < 3; i++) begin
				rts_s7[i] <= scale(rt_s6[i], rtn_s6);
			end
			dg_s7 <= dg_s6 || (rtn_s6 == '0);
			bks_s7 <= bks_s6;

			// upward = back x right
			prd_s8[0] <= $signed(bks_s7[1]) * $signed(rts_s7[2]);
			prd_s8[1] <= $signed(bks_s7[2]) * $signed(rts_s7[1]);
			prd_s8[2] <= $signed(bks_s7[2]) * $signed(rts_s7[0]);
			prd_s8[3] <= $signed(bks_s7[0]) * $signed(rts_s7[2]);
			prd_s8[4] <= $signed(bks_s7[0]) * $signed(rts_s7[1]);
			prd_s8[5] <= $signed(bks_s7[1]) * $signed(rts_s7[0]);
			bks_s8 <= bks_s7;
			rts_s8 <= rts_s7;
			dg_s8 <= dg_s7;

			uw_s9[0] <= prd_s8[0] - prd_s8[1];
			uw_s9[1] <= prd_s8[2] - prd_s8[3];
			uw_s9[2] <= prd_s8[4] - prd_s8[5];
			bks_s9 <= bks_s8;
			rts_s9 <= rts_s8;
			dg_s9 <= dg_s8;

			uwn_s10 <= bit_len(mag_or(uw_s9));
			uw_s10 <= uw_s9;
			bks_s10 <= bks_s9;
			rts_s10 <= rts_s9;
			dg_s10 <= dg_s9;

			for (int i = 0; i < 3; i++) begin
				uws_s11[i] <= scale(uw_s10[i], uwn_s10);
			end
			dg_s11 <= dg_s10 || (uwn_s10 == '0);
			bks_s11 <= bks_s10;
			rts_s11 <= rts_s10;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s1 <= item.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	assign nrm_vec = {bks_s11, uws_s11, rts_s11};
	assign nrm_tag = '{valid: vld_s11, degenerate: dg_s11};

	lab_nrm #(
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) u_nrm (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vec     (nrm_vec),
		.tag     (nrm_tag),
		.res     (res),
		.res_tag (res_tag)
	);

	assign result.valid = res_tag.valid;
	assign result.data = '{
		right_x:    res[0],
		right_y:    res[1],
		right_z:    res[2],
		upward_x:   res[3],
		upward_y:   res[4],
		upward_z:   res[5],
		back_x:     res[6],
		back_y:     res[7],
		back_z:     res[8],
		degenerate: res_tag.degenerate
	};
endmodule
`default_nettype wire
